### src/sgi_pkg.sv
// Shared types and constants for the scan gap interpolator.
// No dependencies; imported by every module of the block.
package sgi_pkg;

  localparam int MAX_STEP_DEF   = 64;
  localparam int RANGE_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int STEP_CFG_W = 7;
  localparam int LEVEL_W    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_FACTOR  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_LEVEL = CFG_IDX_W'(1);

  localparam logic [STEP_CFG_W-1:0] STEP_RESET  = STEP_CFG_W'(1);
  localparam logic [LEVEL_W-1:0]    LEVEL_RESET = LEVEL_W'(2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_PREP,
    S_FILL,
    S_LAST
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic prep;
    logic fill_load;
    logic last_load;
  } cmd_t;

  typedef struct packed {
    logic need_interp;
    logic fill_last;
    logic out_free;
  } sts_t;

endpackage

### src/scan_gap_interpolator_top.sv
// Top level of the scan gap interpolator.
// Instantiates sgi_ctrl and sgi_dpath; depends on sgi_pkg.

// Linear-interpolation upsampler for a range scan measured every Nth beam.
// One item is taken at a time. With no sample held (or N = 1) an item gives
// one result. Otherwise it goes through the one-bit-per-cycle restoring
// divider that forms |new - prev| / N and one setup state, then gives one
// result per cycle through the single output register (fewer when out_ready
// is low). Configuration is to be written only while the block is idle; the
// block itself does not enforce this. cfg_ready is always high.
module scan_gap_interpolator_top #(
  parameter int MAX_STEP   = sgi_pkg::MAX_STEP_DEF,
  parameter int RANGE_BITS = sgi_pkg::RANGE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sgi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sgi_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [RANGE_BITS-1:0]          in_range_mm,
  input  logic                           in_hit_target,
  input  logic [sgi_pkg::LEVEL_W-1:0]    in_return_level,
  input  logic                           in_end_of_scan,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [RANGE_BITS-1:0]          out_range_mm,
  output logic                           out_bright,
  output logic                           out_interpolated,
  output logic                           out_last_of_run
);
  import sgi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sgi_ctrl #(
    .RANGE_BITS(RANGE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sgi_dpath #(
    .MAX_STEP   (MAX_STEP),
    .RANGE_BITS (RANGE_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_range_mm      (in_range_mm),
    .in_hit_target    (in_hit_target),
    .in_return_level  (in_return_level),
    .in_end_of_scan   (in_end_of_scan),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_range_mm     (out_range_mm),
    .out_bright       (out_bright),
    .out_interpolated (out_interpolated),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

### src/sgi_ctrl.sv
// Controller for the scan gap interpolator: sequences accept, divide,
// fill and measured-sample output. Depends on sgi_pkg.
module sgi_ctrl #(
  parameter int RANGE_BITS = sgi_pkg::RANGE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sgi_pkg::sts_t sts,
  output sgi_pkg::cmd_t cmd
);
  import sgi_pkg::*;

  localparam int CNT_W = $clog2(RANGE_BITS);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             cnt_last;

  assign cnt_last = (cnt_r == CNT_W'(RANGE_BITS - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.need_interp ? S_DIV : S_LAST;
        end
      end
      S_DIV: begin
        if (cnt_last) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: state_nxt = S_FILL;
      S_FILL: begin
        if (sts.out_free && sts.fill_last) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cnt_nxt       = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        cnt_nxt    = '0;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
      end
      S_PREP: cmd.prep = 1'b1;
      S_FILL: cmd.fill_load = sts.out_free;
      S_LAST: cmd.last_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### src/sgi_dpath.sv
// Datapath for the scan gap interpolator: config registers, held sample,
// bit-serial divider, incremental fill stepping and output register.
// Depends on sgi_pkg.
module sgi_dpath #(
  parameter int MAX_STEP   = sgi_pkg::MAX_STEP_DEF,
  parameter int RANGE_BITS = sgi_pkg::RANGE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sgi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sgi_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [RANGE_BITS-1:0]          in_range_mm,
  input  logic                           in_hit_target,
  input  logic [sgi_pkg::LEVEL_W-1:0]    in_return_level,
  input  logic                           in_end_of_scan,
  input  sgi_pkg::cmd_t                  cmd,
  output sgi_pkg::sts_t                  sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [RANGE_BITS-1:0]          out_range_mm,
  output logic                           out_bright,
  output logic                           out_interpolated,
  output logic                           out_last_of_run
);
  import sgi_pkg::*;

  localparam int STEP_W = $clog2(MAX_STEP + 1);
  localparam int CMP_W  = (STEP_W > STEP_CFG_W) ? STEP_W : STEP_CFG_W;
  localparam int RB     = RANGE_BITS;

  logic [STEP_CFG_W-1:0] step_r;
  logic [LEVEL_W-1:0]    level_r;

  logic [CMP_W-1:0]  step_ext;
  logic [STEP_W-1:0] n_eff;

  logic [RB-1:0] held_range_r;
  logic          held_bright_r;
  logic          have_held_r;

  logic [RB-1:0] cur_range_r;
  logic          cur_bright_r;
  logic          cur_eos_r;
  logic          neg_r;
  logic [RB-1:0] mag_r;
  logic [RB-1:0] dvd_r;
  logic [STEP_W-1:0] rem_r;
  logic [RB-1:0] q_r;
  logic [STEP_W-1:0] r_r;
  logic [STEP_W-1:0] g_r;

  logic              out_valid_r;
  logic [RB-1:0]     out_range_r;
  logic              out_bright_r;
  logic              out_interp_r;
  logic              out_last_r;

  logic              in_neg;
  logic [STEP_W:0]   rem_sh;
  logic              rem_ge;
  logic              b_nz;
  logic              r_borrow;

  assign cfg_ready = 1'b1;

  always_comb begin
    step_ext = CMP_W'(step_r);
    if (step_ext == '0) begin
      n_eff = STEP_W'(1);
    end else if (step_ext > CMP_W'(MAX_STEP)) begin
      n_eff = STEP_W'(MAX_STEP);
    end else begin
      n_eff = step_ext[STEP_W-1:0];
    end
  end

  assign in_neg   = (in_range_mm < held_range_r);
  assign rem_sh   = {rem_r, dvd_r[RB-1]};
  assign rem_ge   = (rem_sh >= {1'b0, n_eff});
  assign b_nz     = (rem_r != '0);
  assign r_borrow = (r_r < rem_r);

  assign sts.need_interp = have_held_r && (n_eff != STEP_W'(1));
  assign sts.fill_last   = (g_r == STEP_W'(1));
  assign sts.out_free    = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= STEP_RESET;
      level_r <= LEVEL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_STEP_FACTOR:  step_r  <= cfg_data[STEP_CFG_W-1:0];
        REG_BRIGHT_LEVEL: level_r <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_range_r  <= '0;
      held_bright_r <= 1'b0;
      have_held_r   <= 1'b0;
    end else if (cmd.last_load) begin
      held_range_r  <= cur_eos_r ? '0 : cur_range_r;
      held_bright_r <= cur_eos_r ? 1'b0 : cur_bright_r;
      have_held_r   <= !cur_eos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_range_r  <= in_range_mm;
      cur_bright_r <= in_hit_target && (in_return_level >= level_r);
      cur_eos_r    <= in_end_of_scan;
      neg_r        <= in_neg;
      mag_r        <= in_neg ? (held_range_r - in_range_mm) : (in_range_mm - held_range_r);
      dvd_r        <= in_neg ? (held_range_r - in_range_mm) : (in_range_mm - held_range_r);
      rem_r        <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? STEP_W'(rem_sh - {1'b0, n_eff}) : rem_sh[STEP_W-1:0];
      dvd_r <= {dvd_r[RB-2:0], rem_ge};
    end
  end

  // dvd_r holds a = |d| / n and rem_r holds b = |d| % n after the divide.
  // q_r, r_r track g*|d| = q_r*n + r_r, stepped down from g = n-1.
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      q_r <= b_nz ? (mag_r - dvd_r - RB'(1)) : (mag_r - dvd_r);
      r_r <= b_nz ? (n_eff - rem_r) : '0;
      g_r <= n_eff - STEP_W'(1);
    end else if (cmd.fill_load) begin
      if (r_borrow) begin
        r_r <= STEP_W'({1'b0, r_r} + {1'b0, n_eff} - {1'b0, rem_r});
        q_r <= q_r - dvd_r - RB'(1);
      end else begin
        r_r <= r_r - rem_r;
        q_r <= q_r - dvd_r;
      end
      g_r <= g_r - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fill_load || cmd.last_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_load) begin
      out_range_r  <= neg_r ? (cur_range_r + q_r) : (cur_range_r - q_r);
      out_bright_r <= held_bright_r;
      out_interp_r <= 1'b1;
      out_last_r   <= 1'b0;
    end else if (cmd.last_load) begin
      out_range_r  <= cur_range_r;
      out_bright_r <= cur_bright_r;
      out_interp_r <= 1'b0;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_range_mm     = out_range_r;
  assign out_bright       = out_bright_r;
  assign out_interpolated = out_interp_r;
  assign out_last_of_run  = out_last_r;

endmodule

### tb/tb_scan_gap_interpolator_top.sv
// Testbench for scan_gap_interpolator_top: directed and random scans over several step
// and brightness settings, checked against an in-bench interpolation predictor.
// Depends on sgi_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_scan_gap_interpolator_top;
  import sgi_pkg::*;

  localparam int RW         = RANGE_BITS_DEF;
  localparam int STEP_MAX   = MAX_STEP_DEF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_WAIT = 100;

  typedef struct packed {
    logic [RW-1:0] range_mm;
    logic          bright;
    logic          interpolated;
    logic          last_of_run;
  } sample_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [RW-1:0]         in_range_mm;
  logic                  in_hit_target;
  logic [LEVEL_W-1:0]    in_return_level;
  logic                  in_end_of_scan;
  logic                  out_valid;
  logic                  out_ready;
  logic [RW-1:0]         out_range_mm;
  logic                  out_bright;
  logic                  out_interpolated;
  logic                  out_last_of_run;

  logic [STEP_CFG_W-1:0] step_q;
  logic [LEVEL_W-1:0]    bright_level_q;
  logic [RW-1:0]         held_range_q;
  logic                  held_bright_q;
  logic                  have_held_q;

  sample_t expected_samples[$];
  int      err_count = 0;
  int      cycle_count = 0;
  bit      idling;

  scan_gap_interpolator_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_range_mm      (in_range_mm),
    .in_hit_target    (in_hit_target),
    .in_return_level  (in_return_level),
    .in_end_of_scan   (in_end_of_scan),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_range_mm     (out_range_mm),
    .out_bright       (out_bright),
    .out_interpolated (out_interpolated),
    .out_last_of_run  (out_last_of_run)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stalls
  initial begin
    out_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (idling && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  task automatic check_sample();
    sample_t want;
    if (expected_samples.size() == 0) begin
      report_mismatch("unexpected result, range", int'(out_range_mm), 0);
    end else begin
      want = expected_samples.pop_front();
      if (out_range_mm !== want.range_mm)
        report_mismatch("range_mm", int'(out_range_mm), int'(want.range_mm));
      if (out_bright !== want.bright)
        report_mismatch("bright", int'(out_bright), int'(want.bright));
      if (out_interpolated !== want.interpolated)
        report_mismatch("interpolated", int'(out_interpolated), int'(want.interpolated));
      if (out_last_of_run !== want.last_of_run)
        report_mismatch("last_of_run", int'(out_last_of_run), int'(want.last_of_run));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
      check_sample();
  end

  function automatic void predict_samples(input logic [RW-1:0] rng, input logic hit,
                                          input logic [LEVEL_W-1:0] lvl, input logic eos);
    longint  n, g, nr, pr, q, r;
    logic    br;
    sample_t s;
    br = hit && (lvl >= bright_level_q);
    n = step_q;
    if (n < 1) n = 1;
    if (n > STEP_MAX) n = STEP_MAX;
    nr = rng;
    pr = held_range_q;
    if (have_held_q && n > 1) begin
      for (g = n - 1; g >= 1; g--) begin
        q = (g * (nr - pr)) / n;
        r = nr - q;
        if (r < 0) r = 0;
        if (r > (2 ** RW) - 1) r = (2 ** RW) - 1;
        s.range_mm     = r[RW-1:0];
        s.bright       = held_bright_q;
        s.interpolated = 1'b1;
        s.last_of_run  = 1'b0;
        expected_samples.push_back(s);
      end
    end
    s.range_mm     = rng;
    s.bright       = br;
    s.interpolated = 1'b0;
    s.last_of_run  = 1'b1;
    expected_samples.push_back(s);
    if (eos) begin
      held_range_q  = '0;
      held_bright_q = 1'b0;
      have_held_q   = 1'b0;
    end else begin
      held_range_q  = rng;
      held_bright_q = br;
      have_held_q   = 1'b1;
    end
  endfunction

  task automatic send_sample(input logic [RW-1:0] rng, input logic hit,
                             input logic [LEVEL_W-1:0] lvl, input logic eos);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_range_mm     <= rng;
    in_hit_target   <= hit;
    in_return_level <= lvl;
    in_end_of_scan  <= eos;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_samples(rng, hit, lvl, eos);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_samples.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_STEP_FACTOR:  step_q = val[STEP_CFG_W-1:0];
      REG_BRIGHT_LEVEL: bright_level_q = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] step, input logic [LEVEL_W-1:0] lvl);
    wait_drained();
    write_reg(REG_STEP_FACTOR, step);
    write_reg(REG_BRIGHT_LEVEL, lvl);
  endtask

  function automatic logic [RW-1:0] next_range(input logic [RW-1:0] prev);
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = (2 ** RW) - 1;
      2, 3, 4: v = $urandom_range(0, (2 ** RW) - 1);
      default: v = int'(prev) + int'($urandom_range(0, 400)) - 200;
    endcase
    if (v < 0) v = 0;
    if (v > (2 ** RW) - 1) v = (2 ** RW) - 1;
    return v[RW-1:0];
  endfunction

  task automatic run_scans(input int count);
    logic [RW-1:0]      rng;
    logic [LEVEL_W-1:0] lvl;
    int                 k;
    rng = RW'($urandom);
    for (k = 0; k < count; k++) begin
      rng = next_range(rng);
      case ($urandom_range(0, 3))
        0: lvl = bright_level_q;
        1: lvl = bright_level_q - 8'd1;
        default: lvl = LEVEL_W'($urandom);
      endcase
      send_sample(rng, $urandom_range(0, 3) != 0, lvl, $urandom_range(0, 7) == 0);
    end
  endtask

  // step 1, level 2 out of reset
  task automatic test_reset_defaults();
    send_sample(16'd0, 1'b1, 8'd2, 1'b0);
    send_sample(16'hFFFF, 1'b1, 8'd1, 1'b0);
    send_sample(16'h1234, 1'b0, 8'hFF, 1'b0);
    send_sample(16'hA5A5, 1'b1, 8'hFF, 1'b1);
  endtask

  task automatic test_interpolation_extremes();
    configure(8'd4, 8'd0);
    send_sample(16'd0, 1'b1, 8'd0, 1'b0);
    send_sample(16'hFFFF, 1'b0, 8'd0, 1'b0);
    send_sample(16'd0, 1'b1, 8'h80, 1'b0);
    send_sample(16'd0, 1'b1, 8'd7, 1'b0);
    send_sample(16'd3, 1'b1, 8'd7, 1'b1);
    send_sample(16'd1000, 1'b1, 8'd7, 1'b0);
  endtask

  task automatic test_step_limits();
    configure(8'd0, 8'hFF);
    write_reg(2'd2, 8'h55);
    write_reg(2'd3, 8'hAA);
    send_sample(16'd500, 1'b1, 8'hFF, 1'b0);
    send_sample(16'd700, 1'b1, 8'hFE, 1'b0);
    configure(8'h7F, 8'hFF);
    send_sample(16'd100, 1'b1, 8'hFF, 1'b0);
    send_sample(16'hFFFF, 1'b0, 8'hFF, 1'b1);
    configure(8'hC0, 8'd128);
    send_sample(16'hFFFF, 1'b1, 8'd200, 1'b0);
    send_sample(16'd0, 1'b1, 8'd127, 1'b1);
    configure(8'h80, 8'd128);
    send_sample(16'h5A5A, 1'b1, 8'd128, 1'b0);
    send_sample(16'h0101, 1'b1, 8'd128, 1'b0);
  endtask

  // sender waits for all results before each item
  task automatic test_pressure();
    int k;
    configure(8'd5, 8'd100);
    for (k = 0; k < 4; k++) begin
      send_sample(next_range(RW'($urandom)), 1'b1, LEVEL_W'($urandom), k == 3);
      wait_drained();
    end
  endtask

  task automatic test_random_scans();
    int p;
    configure(8'd2, 8'h80);
    run_scans(60);
    configure(8'd3, 8'hFF);
    run_scans(40);
    for (p = 0; p < 5; p++) begin
      configure(CFG_DATA_W'($urandom_range(0, 8)), LEVEL_W'($urandom));
      run_scans(30);
    end
    configure(8'd64, LEVEL_W'($urandom));
    run_scans(15);
  endtask

  task automatic test_final_burst();
    configure(8'd6, LEVEL_W'($urandom));
    idling = 1'b0;
    run_scans(40);
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_range_mm     = '0;
    in_hit_target   = 1'b0;
    in_return_level = '0;
    in_end_of_scan  = 1'b0;
    idling          = 1'b1;
    step_q          = STEP_RESET;
    bright_level_q  = LEVEL_RESET;
    held_range_q    = '0;
    held_bright_q   = 1'b0;
    have_held_q     = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_interpolation_extremes();
    test_step_limits();
    test_pressure();
    test_random_scans();
    test_final_burst();

    in_valid <= 1'b0;
    while (expected_samples.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
src/sgi_pkg.sv
src/sgi_ctrl.sv
src/sgi_dpath.sv
src/scan_gap_interpolator_top.sv
tb/tb_scan_gap_interpolator_top.sv
